// File: design/ddq_pkg.sv
// Shared codes and record types of the deadline-ordered dispatch queue.
`timescale 1ns / 1ps
`default_nettype none

package ddq_pkg;

   localparam logic [1:0] FUNC_TICK     = 2'd0;
   localparam logic [1:0] FUNC_SCHEDULE = 2'd1;
   localparam logic [1:0] FUNC_FETCH    = 2'd2;

   localparam logic [2:0] STAT_SCHEDULED = 3'd0;
   localparam logic [2:0] STAT_FULL      = 3'd1;
   localparam logic [2:0] STAT_RETURNED  = 3'd2;
   localparam logic [2:0] STAT_NOT_DUE   = 3'd3;
   localparam logic [2:0] STAT_EMPTY     = 3'd4;
   localparam logic [2:0] STAT_TICKED    = 3'd5;

   typedef struct packed {
      logic [31:0] expiry;
      logic [15:0] handler;
      logic [31:0] context_tag;
   } entry_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [15:0]        job_handler;
      logic [31:0]        job_context;
      logic signed [31:0] wait_ticks;
   } result_type;

endpackage

`default_nettype wire

// File: design/ddq_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ddq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: design/deadline_ordered_dispatch_queue.sv
// Top level of the deadline-ordered dispatch queue with its sorted job store.
//
// Requests arrive on the req_ stream: tuser selects tick, schedule or fetch,
// and tdata carries delay, handler id and context tag. Every tick, schedule
// and fetch request yields one response on the rsp_ stream, in request
// order; tuser carries the status and tdata the returned job and wait.
// Jobs live in one RAM used as a ring buffer sorted by expiry. A tick
// finishes in the cycle it is accepted, so ticks flow at one per cycle
// while the receiver keeps up. A fetch reads the head entry through the
// registered RAM read port and finishes in the cycle after acceptance. A
// schedule into an empty queue finishes in the cycle it is accepted.
// Otherwise it scans from the tail toward the head, one stored entry per
// cycle, shifting each later entry up by one slot as it goes; that scan
// runs through the single RAM read port. A new request is accepted once
// the previous one has finished. Reset empties the queue and clears the
// tick counter; RAM contents are not cleared. When the receiver stalls,
// a finished response is parked in a holding register and no further
// request is accepted until the output register has room for it.
`timescale 1ns / 1ps
`default_nettype none

module deadline_ordered_dispatch_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // delay [30:0], handler_id [46:31], context_tag [78:47], zero [79]
   input  wire logic [79:0] req_tdata,
   // func [1:0]
   input  wire logic [1:0]  req_tuser,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // job_handler [15:0], job_context [47:16], wait_ticks [79:48]
   output      logic [79:0] rsp_tdata,
   // status [2:0]
   output      logic [2:0]  rsp_tuser
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);
   localparam logic [CNT_W-1:0] TWO_C = CNT_W'(2);
   localparam int ENTRY_W = $bits(ddq_pkg::entry_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PLACE,
      ST_FETCH,
      ST_HOLD
   } state_type;

   state_type              state_ff, state_in;
   logic [31:0]            now_ff, now_in;
   logic [IDX_W-1:0]       head_ff, head_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       pos_ff, pos_in;
   ddq_pkg::entry_type     new_ff, new_in;
   ddq_pkg::result_type    hold_ff, hold_in;
   ddq_pkg::result_type    rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   ddq_pkg::entry_type     wr_entry;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic [ENTRY_W-1:0]     rd_data;
   ddq_pkg::entry_type     rd_entry;

   logic                   req_fire;
   logic                   out_free;
   logic                   fin;
   ddq_pkg::result_type    fin_res;
   logic [31:0]            diff;

   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                             input logic [CNT_W-1:0] lpos);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(head) + (CNT_W+1)'(lpos);
      if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
         sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   ddq_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_entry   = ddq_pkg::entry_type'(rd_data);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign diff       = rd_entry.expiry - now_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {rsp_ff.wait_ticks, rsp_ff.job_context, rsp_ff.job_handler};

   always_comb begin
      state_in     = state_ff;
      now_in       = now_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      new_in       = new_ff;
      hold_in      = hold_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      wr_en        = 1'b0;
      wr_addr      = phys(head_ff, pos_ff);
      wr_entry     = new_ff;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      fin          = 1'b0;
      fin_res      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  ddq_pkg::FUNC_TICK: begin
                     now_in         = now_ff + 32'd1;
                     fin            = 1'b1;
                     fin_res.status = ddq_pkg::STAT_TICKED;
                  end
                  ddq_pkg::FUNC_SCHEDULE: begin
                     if (count_ff == DEPTH_C) begin
                        fin            = 1'b1;
                        fin_res.status = ddq_pkg::STAT_FULL;
                     end else begin
                        new_in.expiry      = now_ff + {1'b0, req_tdata[30:0]};
                        new_in.handler     = req_tdata[46:31];
                        new_in.context_tag = req_tdata[78:47];
                        pos_in             = count_ff;
                        if (count_ff == '0) begin
                           wr_en          = 1'b1;
                           wr_addr        = head_ff;
                           wr_entry       = new_in;
                           count_in       = count_ff + ONE_C;
                           fin            = 1'b1;
                           fin_res.status = ddq_pkg::STAT_SCHEDULED;
                        end else begin
                           rd_en    = 1'b1;
                           rd_addr  = phys(head_ff, count_ff - ONE_C);
                           state_in = ST_SCAN;
                        end
                     end
                  end
                  ddq_pkg::FUNC_FETCH: begin
                     if (count_ff == '0) begin
                        fin            = 1'b1;
                        fin_res.status = ddq_pkg::STAT_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        state_in = ST_FETCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            wr_en = 1'b1;
            if (rd_entry.expiry <= new_ff.expiry) begin
               wr_entry       = new_ff;
               count_in       = count_ff + ONE_C;
               fin            = 1'b1;
               fin_res.status = ddq_pkg::STAT_SCHEDULED;
            end else begin
               wr_entry = rd_entry;
               pos_in   = pos_ff - ONE_C;
               if (pos_ff == ONE_C) begin
                  state_in = ST_PLACE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = phys(head_ff, pos_ff - TWO_C);
               end
            end
         end
         ST_PLACE: begin
            wr_en          = 1'b1;
            wr_addr        = head_ff;
            count_in       = count_ff + ONE_C;
            fin            = 1'b1;
            fin_res.status = ddq_pkg::STAT_SCHEDULED;
         end
         ST_FETCH: begin
            fin                = 1'b1;
            fin_res.wait_ticks = diff;
            if (diff != '0 && !diff[31]) begin
               fin_res.status = ddq_pkg::STAT_NOT_DUE;
            end else begin
               fin_res.status      = ddq_pkg::STAT_RETURNED;
               fin_res.job_handler = rd_entry.handler;
               fin_res.job_context = rd_entry.context_tag;
               head_in             = phys(head_ff, ONE_C);
               count_in            = count_ff - ONE_C;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = hold_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (fin) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_in       = fin_res;
            state_in     = ST_IDLE;
         end else begin
            hold_in  = fin_res;
            state_in = ST_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff  <= pos_in;
      new_ff  <= new_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("Queue occupancy exceeds its depth.");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff < IDX_W'(QUEUE_DEPTH - 1) || head_ff == IDX_W'(QUEUE_DEPTH - 1))
      else $error("Head pointer left the ring.");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |->
      (count_ff == $past(count_ff) || count_ff == $past(count_ff) + ONE_C
      || count_ff == $past(count_ff) - ONE_C))
      else $error("Occupancy changed by more than one job.");

   a_returned_due: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == ddq_pkg::STAT_RETURNED)
      |-> (rsp_ff.wait_ticks == '0 || rsp_ff.wait_ticks[31]))
      else $error("A job was returned before its expiry.");

   a_hold_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD) |-> rsp_valid_ff)
      else $error("A response is parked while the output register is empty.");

endmodule

`default_nettype wire

// File: tb/sv/deadline_ordered_dispatch_queue_checker.sv
// Response checker for the deadline-ordered dispatch queue: predicts each response and compares.
`timescale 1ns / 1ps
`default_nettype none

module deadline_ordered_dispatch_queue_checker #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [79:0] req_tdata,
   input  wire logic [1:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [79:0] rsp_tdata,
   input  wire logic [2:0]  rsp_tuser,
   output int               failures,
   output int               outstanding,
   output int               results_checked
);

   logic [31:0]          tick_count;
   ddq_pkg::entry_type   job_store[QUEUE_DEPTH];
   int                   job_count;
   ddq_pkg::result_type  awaited_outcomes[$];

   function automatic ddq_pkg::result_type dispatch_outcome(logic [1:0] func,
                                                            logic [30:0] delay,
                                                            logic [15:0] handler,
                                                            logic [31:0] ctx);
      ddq_pkg::result_type outcome;
      logic [31:0] expiry;
      logic [31:0] diff;
      int pos;
      outcome = '0;
      case (func)
         ddq_pkg::FUNC_TICK: begin
            tick_count = tick_count + 32'd1;
            outcome.status = ddq_pkg::STAT_TICKED;
         end
         ddq_pkg::FUNC_SCHEDULE: begin
            if (job_count >= QUEUE_DEPTH) begin
               outcome.status = ddq_pkg::STAT_FULL;
            end else begin
               // Equal expiries keep arrival order, so the new job goes after them.
               expiry = tick_count + {1'b0, delay};
               pos = 0;
               while (pos < job_count && job_store[pos].expiry <= expiry) pos++;
               for (int k = job_count; k > pos; k--) job_store[k] = job_store[k - 1];
               job_store[pos].expiry = expiry;
               job_store[pos].handler = handler;
               job_store[pos].context_tag = ctx;
               job_count++;
               outcome.status = ddq_pkg::STAT_SCHEDULED;
            end
         end
         default: begin
            if (job_count == 0) begin
               outcome.status = ddq_pkg::STAT_EMPTY;
            end else begin
               diff = job_store[0].expiry - tick_count;
               outcome.wait_ticks = diff;
               if (diff != 32'd0 && !diff[31]) begin
                  outcome.status = ddq_pkg::STAT_NOT_DUE;
               end else begin
                  outcome.status = ddq_pkg::STAT_RETURNED;
                  outcome.job_handler = job_store[0].handler;
                  outcome.job_context = job_store[0].context_tag;
                  for (int k = 1; k < job_count; k++) job_store[k - 1] = job_store[k];
                  job_count--;
               end
            end
         end
      endcase
      return outcome;
   endfunction

   always @(posedge clock) begin
      ddq_pkg::result_type got;
      ddq_pkg::result_type want;
      if (reset) begin
         tick_count = '0;
         job_count = 0;
         awaited_outcomes.delete();
      end else begin
         if (req_tvalid && req_tready && (req_tuser inside
             {ddq_pkg::FUNC_TICK, ddq_pkg::FUNC_SCHEDULE, ddq_pkg::FUNC_FETCH}))
         begin
            awaited_outcomes.push_back(dispatch_outcome(req_tuser, req_tdata[30:0],
                                                        req_tdata[46:31], req_tdata[78:47]));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser;
            got.job_handler = rsp_tdata[15:0];
            got.job_context = rsp_tdata[47:16];
            got.wait_ticks = rsp_tdata[79:48];
            if (awaited_outcomes.size() == 0) begin
               $error("response with no request pending: status %0d", got.status);
               failures++;
            end else begin
               want = awaited_outcomes.pop_front();
               results_checked++;
               if (got.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, got.status);
                  failures++;
               end
               if (got.job_handler !== want.job_handler) begin
                  $error("job_handler expected %h actual %h", want.job_handler, got.job_handler);
                  failures++;
               end
               if (got.job_context !== want.job_context) begin
                  $error("job_context expected %h actual %h", want.job_context, got.job_context);
                  failures++;
               end
               if (got.wait_ticks !== want.wait_ticks) begin
                  $error("wait_ticks expected %0d actual %0d", want.wait_ticks, got.wait_ticks);
                  failures++;
               end
            end
         end
      end
      outstanding = awaited_outcomes.size();
   end

endmodule

`default_nettype wire

// File: tb/sv/deadline_ordered_dispatch_queue_test.sv
// Testbench top of the deadline-ordered dispatch queue: clock, reset, request stimulus, verdict.
`timescale 1ns / 1ps
`default_nettype none

module deadline_ordered_dispatch_queue_test;

   localparam int         QUEUE_DEPTH = 16;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   int failures;
   int outstanding;
   int results_checked;

   logic steady_tail;
   int   stall_odds;
   int   gap_odds;
   int   tick_requests;
   int   schedule_requests;
   int   fetch_requests;
   int   unused_requests;

   deadline_ordered_dispatch_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   deadline_ordered_dispatch_queue_checker #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .failures(failures),
      .outstanding(outstanding),
      .results_checked(results_checked)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      #3_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         if (!steady_tail && !reset && stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
         begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 10)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_request(logic [1:0] func, logic [30:0] delay, logic [15:0] handler,
                               logic [31:0] ctx);
      if (!steady_tail && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         repeat ($urandom_range(1, 11)) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {1'b0, ctx, handler, delay};
      do @(posedge clock); while (!req_tready);
      case (func)
         ddq_pkg::FUNC_TICK:     tick_requests++;
         ddq_pkg::FUNC_SCHEDULE: schedule_requests++;
         ddq_pkg::FUNC_FETCH:    fetch_requests++;
         default:                unused_requests++;
      endcase
   endtask

   initial begin
      int roll;
      int mode;
      logic [1:0]  func;
      logic [30:0] delay;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = ddq_pkg::FUNC_TICK;
      steady_tail = 1'b0;
      stall_odds = 0;
      gap_odds = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty fetch, field extremes, due and overdue jobs, the unused
      // selector, equal expiries in arrival order, and a schedule into a full store.
      send_request(ddq_pkg::FUNC_FETCH, '0, '0, '0);
      send_request(ddq_pkg::FUNC_TICK, '0, '0, '0);
      send_request(ddq_pkg::FUNC_SCHEDULE, 31'd0, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(ddq_pkg::FUNC_SCHEDULE, 31'h7FFF_FFFF, 16'h0000, 32'h0000_0000);
      send_request(ddq_pkg::FUNC_FETCH, '0, '0, '0);
      send_request(ddq_pkg::FUNC_FETCH, '0, '0, '0);
      send_request(ddq_pkg::FUNC_SCHEDULE, 31'd0, 16'h0001, 32'h0000_0001);
      send_request(ddq_pkg::FUNC_TICK, 31'h7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(ddq_pkg::FUNC_FETCH, 31'h7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(FUNC_UNUSED, 31'h7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         send_request(ddq_pkg::FUNC_SCHEDULE, 31'd5, 16'(16 + i), 32'(i));
      end

      // Random part in groups, each with its own mix of requests and idling.
      for (int group = 0; group < 10; group++) begin
         mode = $urandom_range(0, 2);
         roll = $urandom_range(0, 2);
         gap_odds = (roll == 0) ? 0 : (roll == 1) ? 3 : 8;
         roll = $urandom_range(0, 2);
         stall_odds = (roll == 0) ? 0 : (roll == 1) ? 3 : 8;
         steady_tail = (group == 9);
         for (int n = 0; n < 50; n++) begin
            roll = $urandom_range(0, 99);
            if (roll >= 98) begin
               func = FUNC_UNUSED;
            end else if (mode == 0) begin
               func = (roll < 55) ? ddq_pkg::FUNC_SCHEDULE :
                      (roll < 75) ? ddq_pkg::FUNC_TICK : ddq_pkg::FUNC_FETCH;
            end else if (mode == 1) begin
               func = (roll < 35) ? ddq_pkg::FUNC_TICK :
                      (roll < 65) ? ddq_pkg::FUNC_SCHEDULE : ddq_pkg::FUNC_FETCH;
            end else begin
               func = (roll < 45) ? ddq_pkg::FUNC_TICK :
                      (roll < 55) ? ddq_pkg::FUNC_SCHEDULE : ddq_pkg::FUNC_FETCH;
            end
            roll = $urandom_range(0, 99);
            if (roll == 0) begin
               delay = 31'($urandom);
            end else if (roll < 10) begin
               delay = '0;
            end else begin
               delay = 31'($urandom_range(0, 30));
            end
            send_request(func, delay, 16'($urandom), 32'($urandom));
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      wait (outstanding == 0);
      repeat (QUEUE_DEPTH + 4) @(posedge clock);
      $display("Run covered %0d requests: %0d ticks, %0d schedules, %0d fetches, %0d unused.",
               tick_requests + schedule_requests + fetch_requests + unused_requests,
               tick_requests, schedule_requests, fetch_requests, unused_requests);
      $display("Responses compared field by field: %0d.", results_checked);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
